>>> design/pvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pvt_pkg;

    localparam int ADDR_W         = 32;
    localparam int STAMP_W        = 64;
    localparam int ADDR_BITS_DEF  = 29;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam logic CMD_INVALIDATE = 1'b0;
    localparam logic CMD_QUERY      = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [ADDR_W-1:0] query_length;
    } t_in_beat;

    typedef struct packed {
        logic [STAMP_W-1:0] version;
        logic               rejected;
    } t_out_beat;

endpackage

`default_nettype wire

>>> design/pvt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/pvt_range.sv
`timescale 1ns / 1ps
`default_nettype none

module pvt_range #(
    parameter int ADDR_BITS  = pvt_pkg::ADDR_BITS_DEF,
    parameter int PAGE_SHIFT = pvt_pkg::PAGE_SHIFT_DEF
) (
    input  wire pvt_pkg::t_in_beat               i_item,
    output logic                                 o_reject,
    output logic [ADDR_BITS-PAGE_SHIFT-1:0]      o_first,
    output logic [ADDR_BITS-PAGE_SHIFT-1:0]      o_last
);

    import pvt_pkg::*;

    localparam int             AW1       = ADDR_W + 1;
    localparam logic [AW1-1:0] MEM_BYTES = AW1'(1) << ADDR_BITS;
    localparam logic [AW1-1:0] LAST_BYTE = MEM_BYTES - AW1'(1);

    logic [AW1-1:0] start_x;
    logic [AW1-1:0] end_x;
    logic [AW1-1:0] len_x;
    logic [AW1-1:0] span_left;
    logic [AW1-1:0] q_last;
    logic [AW1-1:0] inv_end;

    assign start_x   = {1'b0, i_item.start_addr};
    assign end_x     = {1'b0, i_item.end_addr};
    assign len_x     = {1'b0, i_item.query_length};
    assign span_left = MEM_BYTES - start_x;
    assign q_last    = start_x + len_x - AW1'(1);
    // clamp a range that runs off the end of memory
    assign inv_end   = (end_x > LAST_BYTE) ? LAST_BYTE : end_x;

    assign o_first = i_item.start_addr[ADDR_BITS-1:PAGE_SHIFT];

    always_comb begin
        unique case (i_item.command)
            CMD_INVALIDATE: begin
                o_reject = (start_x >= MEM_BYTES) || (end_x < start_x);
                o_last   = inv_end[ADDR_BITS-1:PAGE_SHIFT];
            end
            CMD_QUERY: begin
                o_reject = (len_x == '0) || (start_x >= MEM_BYTES) || (len_x > span_left);
                o_last   = q_last[ADDR_BITS-1:PAGE_SHIFT];
            end
            default: begin
                o_reject = 1'b1;
                o_last   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/page_version_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Page version tracker. Keeps one 64-bit write stamp per page of a memory of
// 2^ADDR_BITS bytes cut into pages of 2^PAGE_SHIFT bytes, in a single-port-
// per-side RAM with a registered read. An invalidate beat bumps the
// wrapping sequence counter and stamps every page of its (clamped) byte range;
// a query beat returns the largest stamp over the pages it covers. Ranges that
// are out of memory, reversed or empty come back with rejected set and version
// zero, and change nothing. One item is in flight at a time, and the page
// walk makes one RAM access a cycle. After reset the RAM is swept to zero,
// one page per cycle, over all 2^(ADDR_BITS-PAGE_SHIFT) pages (131072 at the
// defaults); o_in_stall stays high during the sweep. The result sits in an
// output register, so a stalled consumer only holds the block once the next
// result is ready.

module page_version_tracker #(
    parameter int ADDR_BITS  = pvt_pkg::ADDR_BITS_DEF,
    parameter int PAGE_SHIFT = pvt_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pvt_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pvt_pkg::t_out_beat      o_out_data
);

    import pvt_pkg::*;

    localparam int PAGE_W = ADDR_BITS - PAGE_SHIFT;
    localparam int PAGES  = 1 << PAGE_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_WRITE = 6'b001000,
        S_READ  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    // finished result waiting for the output register; the input stays closed
    logic r_emit;
    logic n_emit;

    t_state             r_state, n_state;
    t_in_beat           r_item;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [PAGE_W-1:0]  r_last, n_last;
    logic [STAMP_W-1:0] r_seq, n_seq;
    logic [STAMP_W-1:0] r_max, n_max;
    logic               r_rej, n_rej;
    logic               r_rd_pend;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    logic               in_take;
    logic               rng_reject;
    logic [PAGE_W-1:0]  rng_first;
    logic [PAGE_W-1:0]  rng_last;
    logic               ram_we;
    logic               ram_re;
    logic [STAMP_W-1:0] ram_wdata;
    logic [STAMP_W-1:0] ram_rdata;
    logic               out_free;

    pvt_range #(
        .ADDR_BITS  (ADDR_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_range (
        .i_item   (r_item),
        .o_reject (rng_reject),
        .o_first  (rng_first),
        .o_last   (rng_last)
    );

    pvt_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (PAGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_page),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_page),
        .o_rdata (ram_rdata)
    );

    // take a beat only when fully idle; one item in flight at a time
    assign o_in_stall = (r_state != S_IDLE) || r_emit;
    assign in_take    = i_in_valid && !o_in_stall;

    // the output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // the RAM address is always the walk counter: clear sweep, stamp or read
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign ram_re    = (r_state == S_READ);
    assign ram_wdata = (r_state == S_WRITE) ? r_seq : '0;

    always_comb begin
        n_state     = r_state;
        n_emit      = r_emit;
        n_page      = r_page;
        n_last      = r_last;
        n_seq       = r_seq;
        n_max       = r_max;
        n_rej       = r_rej;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // fold in the stamp read last cycle
        if (r_rd_pend && (ram_rdata > r_max)) begin
            n_max = ram_rdata;
        end

        if (r_emit) begin
            // hold the finished result until the output register frees up
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out.rejected = r_rej;
                if (r_rej) begin
                    n_out.version = '0;
                end else if (r_item.command == CMD_INVALIDATE) begin
                    n_out.version = r_seq;
                end else begin
                    n_out.version = r_max;
                end
                n_emit = 1'b0;
            end
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    // zero one page per cycle after reset
                    if (r_page == {PAGE_W{1'b1}}) begin
                        n_state = S_IDLE;
                    end else begin
                        n_page = r_page + PAGE_W'(1);
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        n_state = S_CHECK;
                    end
                end
                S_CHECK: begin
                    n_page = rng_first;
                    n_last = rng_last;
                    n_max  = '0;
                    n_rej  = rng_reject;
                    if (rng_reject) begin
                        n_state = S_IDLE;
                        n_emit  = 1'b1;
                    end else if (r_item.command == CMD_INVALIDATE) begin
                        // advance the global stamp; wraps through zero
                        n_seq   = r_seq + STAMP_W'(1);
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                end
                S_WRITE: begin
                    if (r_page == r_last) begin
                        n_state = S_IDLE;
                        n_emit  = 1'b1;
                    end else begin
                        n_page = r_page + PAGE_W'(1);
                    end
                end
                S_READ: begin
                    if (r_page == r_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_page = r_page + PAGE_W'(1);
                    end
                end
                S_FLUSH: begin
                    // last read data lands this cycle
                    n_state = S_IDLE;
                    n_emit  = 1'b1;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_emit      <= 1'b0;
            r_page      <= '0;
            r_seq       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit      <= n_emit;
            r_page      <= n_page;
            r_seq       <= n_seq;
            r_rd_pend   <= ram_re;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_data;
        end
        r_last <= n_last;
        r_max  <= n_max;
        r_rej  <= n_rej;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> design/pvt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pvt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire pvt_pkg::t_in_beat  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire pvt_pkg::t_out_beat o_out_data
);

    import pvt_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat dropped or changed");

    // a rejected item reports version zero
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rejected |-> o_out_data.version == '0)
        else $error("rejected beat carries a nonzero version");

    // one item at a time: an accepted beat closes the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    // a result never shows up the cycle right after an accept
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared without any processing time");

endmodule

bind page_version_tracker pvt_checker u_pvt_checker (.*);

`default_nettype wire
